### src/scp_pkg.sv
package scp_pkg;

    localparam int unsigned HDR_LEN      = 10;
    localparam int unsigned FPR_LEN      = 32;
    localparam int unsigned SIGLEN_BYTES = 4;
    localparam int unsigned MAGIC_LEN    = 6;
    localparam int unsigned MAJOR_POS    = 6;
    localparam int unsigned ALG_LO_POS   = 8;
    localparam int unsigned ALG_HI_POS   = 9;
    localparam logic [7:0]  MAJOR_VER    = 8'd1;

    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_ALG  = 3'd1,
        PH_FPR  = 3'd2,
        PH_SLEN = 3'd3,
        PH_SIG  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CLS_HEADER  = 3'd0,
        CLS_ALG     = 3'd1,
        CLS_FPR     = 3'd2,
        CLS_SIG     = 3'd3,
        CLS_DISCARD = 3'd4
    } cls_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_CONT   = 3'd1,
        ST_BAD_MAJOR  = 3'd2,
        ST_BAD_ALG    = 3'd3,
        ST_SHORT_FPR  = 3'd4,
        ST_SHORT_SLEN = 3'd5,
        ST_MISMATCH   = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        cls_t        byte_class;
        logic        done_res;
        status_t     status;
        logic [15:0] alg_length;
        logic [31:0] sig_length;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h51;
            3'd2:    b = 8'h53;
            3'd3:    b = 8'h49;
            3'd4:    b = 8'h47;
            3'd5:    b = 8'h4E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### src/scp_in_stage.sv
module scp_in_stage
    import scp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // data_byte
    input  logic       s_tlast,
    input  logic       take,
    output logic       vld,
    output logic [7:0] data_byte,
    output logic       last
);

    logic       vld_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign s_tready  = !vld_reg || take;
    assign vld       = vld_reg;
    assign data_byte = byte_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

endmodule

### src/scp_parse.sv
module scp_parse
    import scp_pkg::*;
#(
    parameter int unsigned ALG_CAPACITY = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last,
    output result_t    res
);

    localparam logic [16:0] ALG_CAP = 17'(ALG_CAPACITY);

    phase_t      phase_reg,   phase_next;
    logic [15:0] fc_reg,      fc_next;
    logic [3:0]  tot_reg,     tot_next;
    logic [15:0] alg_reg,     alg_next;
    logic [31:0] sig_reg,     sig_next;
    logic [32:0] seen_reg,    seen_next;
    logic        ferr_reg,    ferr_next;
    status_t     perr_reg,    perr_next;

    logic [15:0] fc_inc;
    cls_t        cls;
    status_t     status;

    assign fc_inc = fc_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        fc_next    = fc_reg;
        alg_next   = alg_reg;
        sig_next   = sig_reg;
        seen_next  = seen_reg;
        ferr_next  = ferr_reg;
        perr_next  = perr_reg;
        cls        = CLS_DISCARD;

        if (!ferr_reg)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    cls = CLS_HEADER;
                    if (fc_reg < 16'(MAGIC_LEN))
                    begin
                        if (data_byte != magic_byte(fc_reg[2:0]))
                        begin
                            ferr_next = 1'b1;
                            perr_next = ST_NOT_CONT;
                        end
                    end
                    else if (fc_reg == 16'(MAJOR_POS))
                    begin
                        if (data_byte != MAJOR_VER)
                        begin
                            ferr_next = 1'b1;
                            perr_next = ST_BAD_MAJOR;
                        end
                    end
                    else if (fc_reg == 16'(ALG_LO_POS))
                    begin
                        alg_next = {8'h00, data_byte};
                    end
                    else if (fc_reg == 16'(ALG_HI_POS))
                    begin
                        alg_next = {data_byte, alg_reg[7:0]};
                        if (alg_next == 16'd0 || {1'b0, alg_next} >= ALG_CAP)
                        begin
                            ferr_next = 1'b1;
                            perr_next = ST_BAD_ALG;
                        end
                    end
                    if (!ferr_next && fc_inc >= 16'(HDR_LEN))
                    begin
                        phase_next = PH_ALG;
                        fc_next    = 16'd0;
                    end
                    else
                    begin
                        fc_next = fc_inc;
                    end
                end
                PH_ALG:
                begin
                    cls = CLS_ALG;
                    if (fc_inc >= alg_reg)
                    begin
                        phase_next = PH_FPR;
                        fc_next    = 16'd0;
                    end
                    else
                    begin
                        fc_next = fc_inc;
                    end
                end
                PH_FPR:
                begin
                    cls = CLS_FPR;
                    if (fc_inc >= 16'(FPR_LEN))
                    begin
                        phase_next = PH_SLEN;
                        fc_next    = 16'd0;
                    end
                    else
                    begin
                        fc_next = fc_inc;
                    end
                end
                PH_SLEN:
                begin
                    cls      = CLS_HEADER;
                    sig_next = sig_reg | ({24'h000000, data_byte} << {fc_reg[1:0], 3'b000});
                    if (fc_inc >= 16'(SIGLEN_BYTES))
                    begin
                        phase_next = PH_SIG;
                        fc_next    = 16'd0;
                    end
                    else
                    begin
                        fc_next = fc_inc;
                    end
                end
                PH_SIG:
                begin
                    cls = (seen_reg < {1'b0, sig_reg}) ? CLS_SIG : CLS_DISCARD;
                    if (!seen_reg[32])
                    begin
                        seen_next = seen_reg + 33'd1;
                    end
                end
                default:
                begin
                    cls = CLS_DISCARD;
                end
            endcase
        end

        tot_next = (tot_reg < 4'(HDR_LEN)) ? tot_reg + 4'd1 : tot_reg;

        status = ST_OK;
        if (tot_next < 4'(HDR_LEN))
        begin
            status = ST_NOT_CONT;
        end
        else if (perr_next != ST_OK)
        begin
            status = perr_next;
        end
        else
        begin
            case (phase_next)
                PH_ALG:  status = ST_BAD_ALG;
                PH_FPR:  status = ST_SHORT_FPR;
                PH_SLEN: status = ST_SHORT_SLEN;
                PH_SIG:  status = (seen_next == {1'b0, sig_next}) ? ST_OK : ST_MISMATCH;
                default: status = ST_NOT_CONT;
            endcase
        end

        res.byte_out   = data_byte;
        res.byte_class = cls;
        res.done_res   = last;
        res.status     = last ? status : ST_OK;
        res.alg_length = (last && tot_next >= 4'(HDR_LEN)) ? alg_next : 16'd0;
        res.sig_length = (last && status == ST_OK) ? sig_next : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            fc_reg    <= 16'd0;
            tot_reg   <= 4'd0;
            alg_reg   <= 16'd0;
            sig_reg   <= 32'd0;
            seen_reg  <= 33'd0;
            ferr_reg  <= 1'b0;
            perr_reg  <= ST_OK;
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg <= PH_HDR;
                fc_reg    <= 16'd0;
                tot_reg   <= 4'd0;
                alg_reg   <= 16'd0;
                sig_reg   <= 32'd0;
                seen_reg  <= 33'd0;
                ferr_reg  <= 1'b0;
                perr_reg  <= ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                fc_reg    <= fc_next;
                tot_reg   <= tot_next;
                alg_reg   <= alg_next;
                sig_reg   <= sig_next;
                seen_reg  <= seen_next;
                ferr_reg  <= ferr_next;
                perr_reg  <= perr_next;
            end
        end
    end

endmodule

### src/signature_container_parser.sv
// path: an accepted input beat is held in the input register, then parsed into the output register
// throughput: one beat per cycle while m_tready does not stall the output; a byte
// is parsed as it moves from the input register into the output register
// reset: rst_n clears the parse state to the start of a container and empties
// both registers; the state also returns to the start after each last beat
module signature_container_parser
    import scp_pkg::*;
#(
    parameter int unsigned ALG_CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // byte_out, status, alg_length, sig_length, zero fill
    output logic [2:0]  m_tuser,    // byte_class
    output logic        m_tlast
);

    logic       in_vld;
    logic [7:0] in_byte;
    logic       in_last;
    logic       take;
    result_t    res;

    logic       out_vld_reg;
    result_t    out_reg;

    assign take = in_vld && (!out_vld_reg || m_tready);

    scp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .take      (take),
        .vld       (in_vld),
        .data_byte (in_byte),
        .last      (in_last)
    );

    scp_parse #(
        .ALG_CAPACITY (ALG_CAPACITY)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .data_byte (in_byte),
        .last      (in_last),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_tready)
        begin
            out_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_reg.done_res;
    assign m_tuser  = out_reg.byte_class;
    assign m_tdata  = {5'b00000, out_reg.sig_length, out_reg.alg_length,
                       out_reg.status, out_reg.byte_out};

endmodule
